/* rtl/i2cm_pkg.sv */
// Shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam logic [15:0] PHASE_RESET   = 16'd100;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_SEND    = 3'd2,
		OP_WAITACK = 3'd3,
		OP_RECV    = 3'd4,
		OP_ACK     = 3'd5,
		OP_NACK    = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BUSY   = 2'd1,
		ST_BUSERR = 2'd2
	} status_t;

	// step index of the running command, idle when zero
	typedef enum logic [3:0] {
		SEQ_IDLE = 4'd0,
		SEQ_A1   = 4'd1,
		SEQ_A2   = 4'd2,
		SEQ_A3   = 4'd3,
		SEQ_A4   = 4'd4,
		SEQ_A5   = 4'd5
	} seq_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic [1:0] status;
	} out_item_t;

	// decode stage output: take marks a command that may start
	typedef struct packed {
		logic       take;
		op_t        op;
		logic [7:0] tx_byte;
		logic       sda;
	} cls_item_t;

endpackage

/* rtl/i2cm_stream_if.sv */
// Valid/ready channel carrying one payload per beat.
`timescale 1ns / 1ps

interface i2cm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2cm_front.sv */
// Front stage: takes input beats and decodes the command offered.
`timescale 1ns / 1ps

module i2cm_front
	import i2cm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	i2cm_stream_if.sink        in_ch,
	output logic               push,
	output cls_item_t          push_item,
	input  logic               push_rdy
);

	logic      v_s1;
	cls_item_t item_s1;
	cls_item_t dec;
	logic      accept;

	assign in_ch.ready = !v_s1 || push_rdy;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		dec.take    = in_ch.data.cmd_valid &&
		              (in_ch.data.opcode inside {[OP_START:OP_NACK]});
		dec.op      = dec.take ? op_t'(in_ch.data.opcode) : OP_START;
		dec.tx_byte = (dec.take && dec.op == OP_SEND) ? in_ch.data.tx_byte : 8'd0;
		dec.sda     = in_ch.data.sda_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push_rdy) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= dec;
		end
	end

	assign push      = v_s1;
	assign push_item = item_s1;

endmodule

/* rtl/i2cm_fifo.sv */
// Short fall-through queue between the decode stage and the bit engine.
`timescale 1ns / 1ps

module i2cm_fifo
	import i2cm_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_item,
	output logic      push_rdy,
	input  logic      pop,
	output cls_item_t pop_item,
	output logic      empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cls_item_t         mem_q [DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [CW-1:0]     count_q;
	logic              full;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign push_rdy = !full;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			if (do_pop)  rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue fill count beyond depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |=> count_q == FULL_CNT || $past(pop))
		else $error("queue overrun lost an entry");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("engine stepped on an empty queue");

endmodule

/* rtl/i2cm_back.sv */
// Bit engine: runs one tick per queued entry and registers the result beat.
`timescale 1ns / 1ps

module i2cm_back
	import i2cm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cls_item_t     pop_item,
	input  logic          empty,
	output logic          pop,
	i2cm_stream_if.source out_ch,
	i2cm_stream_if.sink   cfg_ch
);

	localparam logic [3:0] BYTE_BITS = 4'(BITS_PER_BYTE);

	logic [15:0] phase_cfg_q;
	seq_t        seq_q;
	logic [15:0] phase_q;
	logic [3:0]  bit_q;
	logic [7:0]  shift_q;
	op_t         aop_q;
	logic        scl_q, sda_q, ack_q;
	logic [7:0]  rx_q;

	logic        ov_q;
	out_item_t   out_q;

	logic        idle, start_cmd, act;
	op_t         cur_op;
	logic [3:0]  step;
	logic [7:0]  shift_base;
	logic [3:0]  bit_base, bit_inc;
	logic        sda;

	seq_t        seq_nxt;
	logic        fin, cont;
	status_t     st;
	logic [15:0] phase_nxt;
	logic [7:0]  shift_nxt, rx_nxt;
	logic [3:0]  bit_nxt;
	logic        scl_nxt, sda_nxt, ack_nxt;
	out_item_t   res;

	assign cfg_ch.ready = 1'b1;
	assign pop          = !empty && (!ov_q || out_ch.ready);

	assign sda        = pop_item.sda;
	assign idle       = (seq_q == SEQ_IDLE);
	assign start_cmd  = idle && pop_item.take;
	assign act        = start_cmd || (!idle && phase_q <= 16'd1);
	assign cur_op     = start_cmd ? pop_item.op : aop_q;
	assign step       = start_cmd ? 4'd0 : (4'(seq_q) - 4'd1);
	assign shift_base = start_cmd ? pop_item.tx_byte : shift_q;
	assign bit_base   = start_cmd ? 4'd0 : bit_q;
	assign bit_inc    = bit_base + 4'd1;

	// sequencing: which step comes next, and whether this tick finishes
	always_comb begin
		fin     = 1'b0;
		cont    = 1'b0;
		st      = ST_OK;
		seq_nxt = seq_q;
		if (act) begin
			case (cur_op)
				OP_START: begin
					if (step == 4'd0) begin
						cont = 1'b1;
					end else if (step == 4'd1) begin
						if (!sda) begin fin = 1'b1; st = ST_BUSY; end
						else cont = 1'b1;
					end else if (step == 4'd2) begin
						if (sda) begin fin = 1'b1; st = ST_BUSERR; end
						else cont = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
				OP_STOP, OP_ACK, OP_NACK: begin
					if (step <= 4'd3) cont = 1'b1;
					else fin = 1'b1;
				end
				OP_WAITACK: begin
					if (step <= 4'd2) cont = 1'b1;
					else fin = 1'b1;
				end
				OP_SEND: begin
					if (step <= 4'd2) cont = 1'b1;
					else if (bit_inc >= BYTE_BITS) fin = 1'b1;
					else cont = 1'b1;
				end
				default: begin
					if (step <= 4'd1) cont = 1'b1;
					else if (bit_inc >= BYTE_BITS) fin = 1'b1;
					else cont = 1'b1;
				end
			endcase
			if (fin) begin
				seq_nxt = SEQ_IDLE;
			end else if ((cur_op == OP_SEND && step >= 4'd3) ||
			             (cur_op == OP_RECV && step >= 4'd2)) begin
				seq_nxt = SEQ_A2;
			end else begin
				seq_nxt = seq_t'(step + 4'd2);
			end
		end
	end

	// datapath and pin drive for this tick
	always_comb begin
		scl_nxt   = scl_q;
		sda_nxt   = sda_q;
		ack_nxt   = ack_q;
		rx_nxt    = rx_q;
		shift_nxt = shift_base;
		bit_nxt   = bit_base;
		if (act) begin
			case (cur_op)
				OP_START: begin
					if (step == 4'd0) begin
						sda_nxt = 1'b1;
						scl_nxt = 1'b1;
					end else if ((step == 4'd1 && sda) || (step == 4'd2 && !sda)) begin
						sda_nxt = 1'b0;
					end
				end
				OP_STOP: begin
					if (step == 4'd0)      scl_nxt = 1'b0;
					else if (step == 4'd1) sda_nxt = 1'b0;
					else if (step == 4'd2) scl_nxt = 1'b1;
					else if (step == 4'd3) sda_nxt = 1'b1;
				end
				OP_ACK, OP_NACK: begin
					if (step == 4'd0)      scl_nxt = 1'b0;
					else if (step == 4'd1) sda_nxt = (cur_op == OP_NACK);
					else if (step == 4'd2) scl_nxt = 1'b1;
					else if (step == 4'd3) scl_nxt = 1'b0;
				end
				OP_WAITACK: begin
					if (step == 4'd0)      scl_nxt = 1'b0;
					else if (step == 4'd1) sda_nxt = 1'b1;
					else if (step == 4'd2) scl_nxt = 1'b1;
					else begin
						ack_nxt = !sda;
						scl_nxt = 1'b0;
					end
				end
				OP_SEND: begin
					if (step == 4'd0) begin
						scl_nxt = 1'b0;
					end else if (step == 4'd1) begin
						sda_nxt   = shift_base[7];
						shift_nxt = {shift_base[6:0], 1'b0};
					end else if (step == 4'd2) begin
						scl_nxt = 1'b1;
					end else begin
						scl_nxt = 1'b0;
						bit_nxt = bit_inc;
					end
				end
				default: begin
					if (step == 4'd0) begin
						sda_nxt = 1'b1;
						scl_nxt = 1'b0;
					end else if (step == 4'd1) begin
						scl_nxt = 1'b1;
					end else begin
						shift_nxt = {shift_base[6:0], sda};
						scl_nxt   = 1'b0;
						bit_nxt   = bit_inc;
						if (bit_inc >= BYTE_BITS) rx_nxt = {shift_base[6:0], sda};
					end
				end
			endcase
		end

		if (fin) begin
			phase_nxt = 16'd0;
		end else if (cont) begin
			phase_nxt = (phase_cfg_q == 16'd0) ? 16'd1 : phase_cfg_q;
		end else if (!idle) begin
			phase_nxt = phase_q - 16'd1;
		end else begin
			phase_nxt = phase_q;
		end

		res.scl_out  = scl_nxt;
		res.sda_out  = sda_nxt;
		res.busy_res = (seq_nxt != SEQ_IDLE);
		res.done_res = fin;
		res.rx_byte  = rx_nxt;
		res.ack_seen = ack_nxt;
		res.status   = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_cfg_q <= PHASE_RESET;
		end else if (cfg_ch.valid) begin
			phase_cfg_q <= cfg_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= SEQ_IDLE;
			phase_q <= 16'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			aop_q   <= OP_START;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rx_q    <= 8'd0;
		end else if (pop) begin
			seq_q   <= seq_nxt;
			phase_q <= phase_nxt;
			bit_q   <= bit_nxt;
			shift_q <= shift_nxt;
			if (start_cmd) aop_q <= cur_op;
			scl_q   <= scl_nxt;
			sda_q   <= sda_nxt;
			ack_q   <= ack_nxt;
			rx_q    <= rx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.data  = out_q;

	a_idle_no_phase: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_IDLE |-> phase_q == 16'd0)
		else $error("phase counter running while idle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_q.done_res |-> !out_q.busy_res && seq_q == SEQ_IDLE)
		else $error("done beat with engine still busy");

	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_q.done_res |-> out_q.status == ST_OK)
		else $error("status set outside a done beat");

	// the counter rests at the byte length once a byte has finished
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BYTE_BITS)
		else $error("bit counter passed the byte length");

endmodule

/* rtl/i2c_master_byte_engine_top.sv */
// Top level of the I2C master byte engine: decode stage, queue and bit engine.
`timescale 1ns / 1ps

// Each input beat is one tick of the I2C bit engine and gives exactly one
// result beat: the SCL/SDA drive after that tick, busy, a one-tick done flag
// with its status (ok, bus busy at start, bus error at start), the last
// received byte and the last acknowledge seen. Commands are taken only when
// the engine is idle; opcode seven is dropped. Sustained rate is one beat per
// clock: the bit engine retires one queued tick per cycle whenever the result
// register is free or being drained. An accepted beat passes the decode
// register, the queue and the result register before it is offered on
// out_ch, and the queue of QUEUE_DEPTH entries lets input and output stall
// independently.
// The phase length is written on cfg_ch (always ready) and sets how many ticks each
// bus phase lasts; zero acts as one. Write it only while the engine is idle.

module i2c_master_byte_engine_top
	import i2cm_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	i2cm_stream_if.sink   in_ch,
	i2cm_stream_if.source out_ch,
	i2cm_stream_if.sink   cfg_ch
);

	// decode stage to queue
	logic      push;
	logic      push_rdy;
	cls_item_t push_item;

	// queue to bit engine
	logic      pop;
	logic      empty;
	cls_item_t pop_item;

	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.push      (push),
		.push_item (push_item),
		.push_rdy  (push_rdy)
	);

	i2cm_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.push_rdy  (push_rdy),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	i2cm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_item (pop_item),
		.empty    (empty),
		.pop      (pop),
		.out_ch   (out_ch),
		.cfg_ch   (cfg_ch)
	);

endmodule
